// ----- rtl/core/sdhs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdhs_pkg
// Shared types and codes for the SCAN disk head seek model.
// ----------------------------------------------------------------------------
package sdhs_pkg;

  localparam int AddrW    = 32;
  localparam int TrackW   = 16;
  localparam int SectorW  = 16;
  localparam int StepsW   = 17;
  localparam int TimeW    = 32;
  localparam int ServiceW = 50;
  localparam int CfgIdxW  = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_TRACK_COUNT  = 3'd0,
    REG_SECTORS      = 3'd1,
    REG_TRACK_TIME   = 3'd2,
    REG_SECTOR_TIME  = 3'd3,
    REG_START_TRACK  = 3'd4,
    REG_START_SECTOR = 3'd5
  } sdhs_reg_t;

  typedef struct packed {
    logic [TrackW-1:0]  track_count;
    logic [SectorW-1:0] sectors_per_track;
    logic [TimeW-1:0]   track_time;
    logic [TimeW-1:0]   sector_time;
  } sdhs_cfg_t;

  typedef struct packed {
    logic              load_track;
    logic              load_sector;
    logic [TrackW-1:0] value;
  } sdhs_head_load_t;

  typedef struct packed {
    logic [TrackW-1:0]  track;
    logic [SectorW-1:0] sector;
    logic               oor;
  } sdhs_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sdhs_q_stat_t;

endpackage
`default_nettype wire

// ----- rtl/core/sdhs_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdhs_front
// Accepts a logical address, splits it into track and sector with a
// bit-serial restoring divider and classifies it against the disk capacity.
// ----------------------------------------------------------------------------
module sdhs_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire sdhs_pkg::sdhs_cfg_t          cfg,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [sdhs_pkg::AddrW-1:0]   in_logical_address,
  input  wire sdhs_pkg::sdhs_q_stat_t       q_stat,
  output logic                              push,
  output sdhs_pkg::sdhs_req_t               push_data
);
  import sdhs_pkg::*;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} front_state_t;

  front_state_t       state_r;
  logic [AddrW-1:0]   quo_r;
  logic [AddrW-1:0]   quo_nxt;
  logic [SectorW-1:0] rem_r;
  logic [SectorW-1:0] rem_nxt;
  logic [4:0]         cnt_r;
  logic [SectorW:0]   rem_sh;
  logic [SectorW:0]   rem_diff;
  logic               fits;

  assign rem_sh   = {rem_r, quo_r[AddrW-1]};
  assign rem_diff = rem_sh - {1'b0, cfg.sectors_per_track};
  assign fits     = rem_sh >= {1'b0, cfg.sectors_per_track};
  assign rem_nxt  = fits ? rem_diff[SectorW-1:0] : rem_sh[SectorW-1:0];
  assign quo_nxt  = {quo_r[AddrW-2:0], fits};

  assign in_stall = (state_r != F_IDLE);
  assign push     = (state_r == F_PUSH) && !q_stat.full;

  assign push_data.track  = quo_r[TrackW-1:0];
  assign push_data.sector = rem_r;
  assign push_data.oor    = (cfg.sectors_per_track == '0) ||
                            (quo_r >= {{(AddrW-TrackW){1'b0}}, cfg.track_count});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            quo_r   <= in_logical_address;
            rem_r   <= '0;
            cnt_r   <= '0;
            state_r <= F_DIV;
          end
        end
        F_DIV: begin
          quo_r <= quo_nxt;
          rem_r <= rem_nxt;
          cnt_r <= cnt_r + 5'd1;
          if (&cnt_r) begin
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (!q_stat.full) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sdhs_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdhs_queue
// Two-entry queue of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module sdhs_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   push,
  input  wire sdhs_pkg::sdhs_req_t    push_data,
  input  wire logic                   pop,
  output sdhs_pkg::sdhs_req_t         pop_data,
  output sdhs_pkg::sdhs_q_stat_t      q_stat
);
  import sdhs_pkg::*;

  sdhs_req_t  mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign pop_data     = mem_r[rd_ptr_r];
  assign q_stat.full  = count_r[1];
  assign q_stat.empty = (count_r == 2'd0);

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        count_r <= count_r + 2'd1;
      end else if (pop && !push) begin
        count_r <= count_r - 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sdhs_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdhs_back
// Moves the simulated head by SCAN rules, counts track and sector steps,
// forms the service time and holds the result beat in an output register.
// ----------------------------------------------------------------------------
module sdhs_back #(
  parameter int TRACK_BITS  = 16,
  parameter int SECTOR_BITS = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire sdhs_pkg::sdhs_cfg_t           cfg,
  input  wire sdhs_pkg::sdhs_head_load_t     head_load,
  input  wire sdhs_pkg::sdhs_q_stat_t        q_stat,
  input  wire sdhs_pkg::sdhs_req_t           pop_data,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [sdhs_pkg::TrackW-1:0]        out_target_track,
  output logic [sdhs_pkg::SectorW-1:0]       out_target_sector,
  output logic [sdhs_pkg::StepsW-1:0]        out_track_steps,
  output logic [sdhs_pkg::SectorW-1:0]       out_sector_steps,
  output logic [sdhs_pkg::ServiceW-1:0]      out_service_time,
  output logic                               out_out_of_range
);
  import sdhs_pkg::*;

  typedef enum logic [1:0] {B_IDLE, B_MUL, B_SUM} back_state_t;

  localparam int PtW = StepsW + TimeW;
  localparam int PsW = SectorW + TimeW;

  back_state_t            state_r;
  logic [TRACK_BITS-1:0]  head_track_r;
  logic [SECTOR_BITS-1:0] head_sector_r;
  logic                   moving_down_r;

  logic [TrackW-1:0]      tgt_track_r;
  logic [SectorW-1:0]     tgt_sector_r;
  logic [StepsW-1:0]      tsteps_r;
  logic [SectorW-1:0]     ssteps_r;
  logic                   oor_r;
  logic [PtW-1:0]         prod_t_r;
  logic [PsW-1:0]         prod_s_r;

  logic                   out_valid_r;
  logic [TrackW-1:0]      out_track_r;
  logic [SectorW-1:0]     out_sector_r;
  logic [StepsW-1:0]      out_tsteps_r;
  logic [SectorW-1:0]     out_ssteps_r;
  logic [ServiceW-1:0]    out_time_r;
  logic                   out_oor_r;

  logic [StepsW-1:0]      t_x;
  logic [StepsW-1:0]      c_x;
  logic [StepsW-1:0]      p_x;
  logic [StepsW-1:0]      s_x;
  logic [StepsW-1:0]      scnt_x;
  logic [StepsW-1:0]      hraw_x;
  logic [StepsW-1:0]      h_x;
  logic [StepsW-1:0]      tsteps_nxt;
  logic                   down_nxt;
  logic [StepsW-1:0]      diff_x;
  logic [SectorW-1:0]     ssteps_nxt;
  logic [StepsW-1:0]      sec_inc;
  logic [SectorW-1:0]     sec_nxt;
  logic                   out_free;

  assign t_x    = {1'b0, pop_data.track};
  assign s_x    = {1'b0, pop_data.sector};
  assign c_x    = {1'b0, TrackW'(head_track_r)};
  assign hraw_x = {1'b0, SectorW'(head_sector_r)};
  assign p_x    = {1'b0, cfg.track_count};
  assign scnt_x = {1'b0, cfg.sectors_per_track};

  always_comb begin
    tsteps_nxt = '0;
    down_nxt   = moving_down_r;
    if (t_x == c_x) begin
      tsteps_nxt = '0;
    end else if (!moving_down_r) begin
      if (t_x > c_x) begin
        tsteps_nxt = t_x - c_x + 17'd1;
      end else begin
        tsteps_nxt = ((c_x < p_x) ? (p_x - c_x) : '0) + (p_x - 17'd1 - t_x);
        down_nxt   = 1'b1;
      end
    end else begin
      if (t_x < c_x) begin
        tsteps_nxt = c_x - t_x + 17'd1;
      end else begin
        tsteps_nxt = c_x + 17'd1 + t_x;
        down_nxt   = 1'b0;
      end
    end
  end

  assign h_x        = (hraw_x >= scnt_x) ? (scnt_x - 17'd1) : hraw_x;
  assign diff_x     = (s_x >= h_x) ? (s_x - h_x) : (s_x + scnt_x - h_x);
  assign ssteps_nxt = diff_x[SectorW-1:0] + 16'd1;
  assign sec_inc    = s_x + 17'd1;
  assign sec_nxt    = (sec_inc == scnt_x) ? '0 : sec_inc[SectorW-1:0];

  assign pop      = (state_r == B_IDLE) && !q_stat.empty;
  assign out_free = !out_valid_r || !out_stall;

  assign out_valid         = out_valid_r;
  assign out_target_track  = out_track_r;
  assign out_target_sector = out_sector_r;
  assign out_track_steps   = out_tsteps_r;
  assign out_sector_steps  = out_ssteps_r;
  assign out_service_time  = out_time_r;
  assign out_out_of_range  = out_oor_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= B_IDLE;
      head_track_r  <= '0;
      head_sector_r <= '0;
      moving_down_r <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if ((state_r == B_SUM) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (head_load.load_track) begin
        head_track_r <= TRACK_BITS'(head_load.value);
      end
      if (head_load.load_sector) begin
        head_sector_r <= SECTOR_BITS'(head_load.value);
      end
      unique case (state_r)
        B_IDLE: begin
          if (pop) begin
            oor_r <= pop_data.oor;
            if (pop_data.oor) begin
              tgt_track_r  <= '0;
              tgt_sector_r <= '0;
              tsteps_r     <= '0;
              ssteps_r     <= '0;
            end else begin
              tgt_track_r   <= pop_data.track;
              tgt_sector_r  <= pop_data.sector;
              tsteps_r      <= tsteps_nxt;
              ssteps_r      <= ssteps_nxt;
              head_track_r  <= TRACK_BITS'(pop_data.track);
              head_sector_r <= SECTOR_BITS'(sec_nxt);
              moving_down_r <= down_nxt;
            end
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          prod_t_r <= PtW'(tsteps_r) * PtW'(cfg.track_time);
          prod_s_r <= PsW'(ssteps_r) * PsW'(cfg.sector_time);
          state_r  <= B_SUM;
        end
        B_SUM: begin
          if (out_free) begin
            out_track_r  <= tgt_track_r;
            out_sector_r <= tgt_sector_r;
            out_tsteps_r <= tsteps_r;
            out_ssteps_r <= ssteps_r;
            out_time_r   <= ServiceW'(prod_t_r) + ServiceW'(prod_s_r);
            out_oor_r    <= oor_r;
            state_r      <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/scan_disk_head_seek_model_top.sv -----
`default_nettype none
// Each address is split by the 32-step serial divider; the input stalls until the
// split request has been pushed into the queue, then the next address may be taken.
// A two-entry queue lets the divider start the next address while a result waits.
// Reset: synchronous active-low rst_n restores the registers to their defaults,
// puts the head on track 0, sector 0, ascending, and empties the queue.
// ----------------------------------------------------------------------------
// scan_disk_head_seek_model_top
// SCAN elevator disk seek time model: address split, head movement and
// service time, with a register write port for the disk geometry and timing.
// ----------------------------------------------------------------------------
module scan_disk_head_seek_model_top #(
  parameter int TRACK_BITS  = 16,
  parameter int SECTOR_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [sdhs_pkg::CfgIdxW-1:0]      cfg_index,
  input  wire logic [sdhs_pkg::TimeW-1:0]        cfg_data,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire logic [sdhs_pkg::AddrW-1:0]        in_logical_address,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output logic [sdhs_pkg::TrackW-1:0]            out_target_track,
  output logic [sdhs_pkg::SectorW-1:0]           out_target_sector,
  output logic [sdhs_pkg::StepsW-1:0]            out_track_steps,
  output logic [sdhs_pkg::SectorW-1:0]           out_sector_steps,
  output logic [sdhs_pkg::ServiceW-1:0]          out_service_time,
  output logic                                   out_out_of_range
);
  import sdhs_pkg::*;

  sdhs_cfg_t       cfg_r;
  sdhs_head_load_t head_load;
  sdhs_q_stat_t    q_stat;
  sdhs_req_t       push_data;
  sdhs_req_t       pop_data;
  logic            push;
  logic            pop;
  logic            cfg_wr;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_comb begin
    head_load.load_track  = 1'b0;
    head_load.load_sector = 1'b0;
    head_load.value       = cfg_data[TrackW-1:0];
    if (cfg_wr) begin
      unique case (cfg_index)
        REG_START_TRACK:  head_load.load_track  = 1'b1;
        REG_START_SECTOR: head_load.load_sector = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.track_count       <= 16'd1024;
      cfg_r.sectors_per_track <= 16'd1024;
      cfg_r.track_time        <= 32'd65536;
      cfg_r.sector_time       <= 32'd65536;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_TRACK_COUNT: cfg_r.track_count       <= cfg_data[TrackW-1:0];
        REG_SECTORS:     cfg_r.sectors_per_track <= cfg_data[SectorW-1:0];
        REG_TRACK_TIME:  cfg_r.track_time        <= cfg_data;
        REG_SECTOR_TIME: cfg_r.sector_time       <= cfg_data;
        default: ;
      endcase
    end
  end

  sdhs_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg_r),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_logical_address (in_logical_address),
    .q_stat             (q_stat),
    .push               (push),
    .push_data          (push_data)
  );

  sdhs_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  sdhs_back #(
    .TRACK_BITS  (TRACK_BITS),
    .SECTOR_BITS (SECTOR_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .head_load         (head_load),
    .q_stat            (q_stat),
    .pop_data          (pop_data),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_target_track  (out_target_track),
    .out_target_sector (out_target_sector),
    .out_track_steps   (out_track_steps),
    .out_sector_steps  (out_sector_steps),
    .out_service_time  (out_service_time),
    .out_out_of_range  (out_out_of_range)
  );

endmodule
`default_nettype wire

// ----- rtl/core/sdhs_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sdhs_checker
// Port-level checks for the SCAN disk head seek model, bound to the top level.
// ----------------------------------------------------------------------------
module sdhs_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire logic [sdhs_pkg::TrackW-1:0]       out_target_track,
  input wire logic [sdhs_pkg::SectorW-1:0]      out_target_sector,
  input wire logic [sdhs_pkg::StepsW-1:0]       out_track_steps,
  input wire logic [sdhs_pkg::SectorW-1:0]      out_sector_steps,
  input wire logic [sdhs_pkg::ServiceW-1:0]     out_service_time,
  input wire logic                              out_out_of_range
);
  import sdhs_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_service_time) &&
      $stable(out_target_track) && $stable(out_target_sector))
    else $error("result beat changed while stalled");

  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> out_target_track == '0 &&
      out_target_sector == '0 && out_track_steps == '0 &&
      out_sector_steps == '0 && out_service_time == '0)
    else $error("out-of-range beat carries nonzero fields");

  a_sector_steps: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_out_of_range |-> out_sector_steps != '0)
    else $error("valid seek with zero sector steps");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again before the address split finished");

endmodule

bind scan_disk_head_seek_model_top sdhs_checker u_sdhs_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_target_track  (out_target_track),
  .out_target_sector (out_target_sector),
  .out_track_steps   (out_track_steps),
  .out_sector_steps  (out_sector_steps),
  .out_service_time  (out_service_time),
  .out_out_of_range  (out_out_of_range)
);
`default_nettype wire
